// File: src/pgc_pkg.sv
// Shared types, constants and saturating adders for the genotype pair correlation unit.
package pgc_pkg;

    localparam int LANES    = 4;
    localparam int ENTRY_W  = 24;
    localparam int FREQ_W   = 17;
    localparam int MARKER_W = 24;
    localparam int PROD_W   = 48;

    localparam logic [FREQ_W-1:0] FREQ_ONE = 17'd65536;
    localparam logic [62:0]       SQ_LIM   = {63{1'b1}};

    typedef logic [ENTRY_W-1:0] entry_t;
    typedef entry_t [3:0] dec_tbl_t;

    // 2-bit genotype codes
    localparam logic [1:0] CODE_HOM_REF = 2'd0;
    localparam logic [1:0] CODE_MISSING = 2'd1;
    localparam logic [1:0] CODE_HET     = 2'd2;
    localparam logic [1:0] CODE_HOM_ALT = 2'd3;

    typedef struct packed {
        logic              start;
        logic              stdz;
        logic [FREQ_W-1:0] freq_a;
        logic [FREQ_W-1:0] freq_b;
    } setup_req_t;

    typedef struct packed {
        logic [PROD_W-1:0] sq_a;
        logic [PROD_W-1:0] sq_b;
        logic [PROD_W-1:0] xprod;
    } lane_prod_t;

    typedef struct packed {
        logic        done;
        logic        valid;
        logic [15:0] corr;
    } corr_res_t;

    function automatic logic [62:0] sat_add_u63(logic [62:0] a, logic [PROD_W-1:0] b);
        logic [63:0] s;
        s = {1'b0, a} + {16'b0, b};
        return s[63] ? SQ_LIM : s[62:0];
    endfunction

    function automatic logic [63:0] sat_add_s64(logic [63:0] a, logic [PROD_W-1:0] b);
        logic [64:0] s;
        s = {a[63], a} + {{17{b[PROD_W-1]}}, b};
        if (s[64] != s[63]) begin
            return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end
        return s[63:0];
    endfunction

endpackage

// File: src/packed_genotype_pair_correlation_unit.sv
// Top level: item control, four decode lanes, saturating merge and result register.
//
//  channel  dir  handshake             contents
//  s_       in   s_tvalid / s_tready   genotype bytes, codes, freqs, markers; s_tlast = last byte
//  m_       out  m_tvalid / m_tready   indices, sums, correlation; m_tuser = correlation valid
//  cfg_     in   cfg_wr_en             standardize bit
//
// One item at a time: accept, then the lane state, then the merge state, which adds one lane per step.
// The first item of a pair first runs the table fill: raw; or standardized, with a
// 64-step divider and a 32-step root per nonzero entry, while zero entries skip both.
// A last item then runs the correlation unit (two 64-step multiplies, 160-step divide,
// 17-step root), which skips these when a square sum is zero. Synchronous active-low reset.
// A waiting result holds in the output register; only the next last item stalls on it.
module packed_genotype_pair_correlation_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] genotype_byte_a, [15:8] genotype_byte_b, [18:16] valid_codes,
    // [35:19] freq_a, [52:36] freq_b, [76:53] marker_a, [100:77] marker_b
    input  logic [103:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [23:0] index_a, [47:24] index_b, [110:48] sum_sq_a, [173:111] sum_sq_b,
    // [237:174] cross_sum, [253:238] correlation
    output logic [255:0] m_tdata,
    // [0] correlation_valid
    output logic         m_tuser
);
    import pgc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SETUP = 6'b000010,
        ST_LANES = 6'b000100,
        ST_MERGE = 6'b001000,
        ST_CORR  = 6'b010000,
        ST_OUT   = 6'b100000
    } top_st_t;

    top_st_t             state_reg, state_next;
    logic                stdz_reg;
    logic                pair_open_reg;
    logic                setup_start_reg;
    logic                corr_start_reg;
    logic [1:0]          lane_idx_reg;
    logic [7:0]          ga_reg, gb_reg;
    logic [2:0]          nv_reg;
    logic                last_reg;
    logic [FREQ_W-1:0]   fa_reg, fb_reg;
    logic [MARKER_W-1:0] ma_reg, mb_reg;
    logic [62:0]         acc_sq_a_reg, acc_sq_b_reg;
    logic [63:0]         acc_cross_reg;
    logic                m_valid_reg;
    logic [255:0]        m_data_reg;
    logic                m_user_reg;

    logic                accept_w;
    logic                out_free_w;
    logic                out_load_w;
    logic [FREQ_W-1:0]   fa_in_w, fb_in_w;
    setup_req_t          setup_req;
    logic                setup_done;
    dec_tbl_t            tbl_a, tbl_b;
    lane_prod_t          prod [LANES];
    corr_res_t           corr_res;

    assign s_tready   = (state_reg == ST_IDLE);
    assign accept_w   = s_tvalid && s_tready;
    assign out_free_w = !m_valid_reg || m_tready;
    assign out_load_w = ((state_reg == ST_CORR && corr_res.done) || state_reg == ST_OUT)
                        && out_free_w;

    assign fa_in_w = (s_tdata[35:19] > FREQ_ONE) ? FREQ_ONE : s_tdata[35:19];
    assign fb_in_w = (s_tdata[52:36] > FREQ_ONE) ? FREQ_ONE : s_tdata[52:36];

    assign setup_req.start  = setup_start_reg;
    assign setup_req.stdz   = stdz_reg;
    assign setup_req.freq_a = fa_reg;
    assign setup_req.freq_b = fb_reg;

    pgc_setup u_setup (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (setup_req),
        .done    (setup_done),
        .tbl_a   (tbl_a),
        .tbl_b   (tbl_b)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        pgc_lane u_lane (
            .aclk     (aclk),
            .load     (state_reg == ST_LANES),
            .use_code (nv_reg > 3'(i)),
            .code_a   (ga_reg[2*i +: 2]),
            .code_b   (gb_reg[2*i +: 2]),
            .tbl_a    (tbl_a),
            .tbl_b    (tbl_b),
            .prod     (prod[i])
        );
    end

    pgc_corr u_corr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (corr_start_reg),
        .sa      (acc_sq_a_reg),
        .sb      (acc_sq_b_reg),
        .c       (acc_cross_reg),
        .res     (corr_res)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept_w) state_next = pair_open_reg ? ST_LANES : ST_SETUP;
            ST_SETUP: if (setup_done) state_next = ST_LANES;
            ST_LANES: state_next = ST_MERGE;
            ST_MERGE: if (lane_idx_reg == 2'(LANES - 1)) state_next = last_reg ? ST_CORR : ST_IDLE;
            ST_CORR: begin
                if (corr_res.done) state_next = out_free_w ? ST_IDLE : ST_OUT;
            end
            ST_OUT:   if (out_free_w) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            stdz_reg        <= 1'b1;
            pair_open_reg   <= 1'b0;
            setup_start_reg <= 1'b0;
            corr_start_reg  <= 1'b0;
            lane_idx_reg    <= '0;
            acc_sq_a_reg    <= '0;
            acc_sq_b_reg    <= '0;
            acc_cross_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            setup_start_reg <= accept_w && !pair_open_reg;
            corr_start_reg  <= (state_reg == ST_MERGE) && (lane_idx_reg == 2'(LANES - 1))
                               && last_reg;
            if (cfg_wr_en) stdz_reg <= cfg_wr_data;
            if (accept_w) pair_open_reg <= 1'b1;
            if (state_reg == ST_LANES) lane_idx_reg <= '0;
            if (state_reg == ST_MERGE) begin
                lane_idx_reg  <= lane_idx_reg + 2'd1;
                acc_sq_a_reg  <= sat_add_u63(acc_sq_a_reg, prod[lane_idx_reg].sq_a);
                acc_sq_b_reg  <= sat_add_u63(acc_sq_b_reg, prod[lane_idx_reg].sq_b);
                acc_cross_reg <= sat_add_s64(acc_cross_reg, prod[lane_idx_reg].xprod);
            end
            if (out_load_w) begin
                acc_sq_a_reg  <= '0;
                acc_sq_b_reg  <= '0;
                acc_cross_reg <= '0;
                pair_open_reg <= 1'b0;
            end
            if (out_load_w)    m_valid_reg <= 1'b1;
            else if (m_tready) m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_w) begin
            ga_reg   <= s_tdata[7:0];
            gb_reg   <= s_tdata[15:8];
            nv_reg   <= s_tdata[18:16];
            fa_reg   <= fa_in_w;
            fb_reg   <= fb_in_w;
            ma_reg   <= s_tdata[76:53];
            mb_reg   <= s_tdata[100:77];
            last_reg <= s_tlast;
        end
        if (out_load_w) begin
            m_data_reg <= {2'b0, corr_res.corr, acc_cross_reg, acc_sq_b_reg,
                           acc_sq_a_reg, mb_reg, ma_reg};
            m_user_reg <= corr_res.valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: src/pgc_setup.sv
// Per-pair decode table fill: raw dosages, or standardized values via divide and square root.
module pgc_setup (
    input  logic                aclk,
    input  logic                aresetn,
    input  pgc_pkg::setup_req_t req,
    output logic                done,
    output pgc_pkg::dec_tbl_t   tbl_a,
    output pgc_pkg::dec_tbl_t   tbl_b
);
    import pgc_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_PREP  = 6'b000010,
        ST_JOB   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_SQRT  = 6'b010000,
        ST_WRITE = 6'b100000
    } setup_st_t;

    setup_st_t         state_reg, state_next;
    logic              done_reg, done_next;
    logic              stdz_reg;
    logic [FREQ_W-1:0] fa_reg, fb_reg;
    logic [31:0]       va_reg, vb_reg;
    logic              side_reg;
    logic [1:0]        code_reg;
    logic              neg_reg;
    logic              zero_reg;
    logic [63:0]       div_n_reg;
    logic [32:0]       rem_reg;
    logic [63:0]       quo_reg;
    logic [5:0]        cnt_reg;
    logic [63:0]       sq_x_reg, sq_r_reg, sq_bit_reg;
    dec_tbl_t          tbl_a_reg, tbl_b_reg;

    logic [33:0]       pa_w, pb_w;
    logic [FREQ_W-1:0] f_sel;
    logic [31:0]       v_sel;
    logic [1:0]        d_w;
    logic [18:0]       num_w, mag_w;
    logic [35:0]       mag2_w;
    logic [32:0]       rem_sh_w;
    logic              qbit_w;
    logic [63:0]       trial_w;
    logic [63:0]       q_w;
    logic [ENTRY_W-1:0] qcap_w, entry_w;

    assign pa_w  = 34'(fa_reg * (FREQ_ONE - fa_reg));
    assign pb_w  = 34'(fb_reg * (FREQ_ONE - fb_reg));
    assign f_sel = side_reg ? fb_reg : fa_reg;
    assign v_sel = side_reg ? vb_reg : va_reg;

    always_comb begin
        case (code_reg)
            CODE_HOM_REF: d_w = 2'd2;
            CODE_HET:     d_w = 2'd1;
            default:      d_w = 2'd0;
        endcase
    end

    assign num_w    = {1'b0, d_w, 16'b0} - {1'b0, f_sel, 1'b0};
    assign mag_w    = num_w[18] ? (19'd0 - num_w) : num_w;
    assign mag2_w   = mag_w[17:0] * mag_w[17:0];
    assign rem_sh_w = {rem_reg[31:0], div_n_reg[63]};
    assign qbit_w   = rem_sh_w >= {1'b0, v_sel};
    assign trial_w  = sq_r_reg + sq_bit_reg;
    assign q_w      = (sq_r_reg + 64'd1) >> 1;
    assign qcap_w   = (q_w > 64'd8388607) ? 24'd8388607 : q_w[ENTRY_W-1:0];
    assign entry_w  = zero_reg ? '0 : (neg_reg ? (24'd0 - qcap_w) : qcap_w);

    function automatic entry_t raw_entry(logic [1:0] code, logic [FREQ_W-1:0] f);
        logic [FREQ_W:0] s;
        s = {1'b0, f} + 18'd4;
        case (code)
            CODE_HOM_REF: return 24'd8192;
            CODE_MISSING: return {9'b0, s[17:3]};
            CODE_HET:     return 24'd4096;
            default:      return '0;
        endcase
    endfunction

    always_comb begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            ST_IDLE:  if (req.start) state_next = ST_PREP;
            ST_PREP: begin
                if (stdz_reg) begin
                    state_next = ST_JOB;
                end else begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end
            end
            ST_JOB: begin
                if (v_sel == '0 || code_reg == CODE_MISSING) state_next = ST_WRITE;
                else                                         state_next = ST_DIV;
            end
            ST_DIV:   if (cnt_reg == 6'd63) state_next = ST_SQRT;
            ST_SQRT:  if (cnt_reg == 6'd31) state_next = ST_WRITE;
            ST_WRITE: begin
                if (code_reg == CODE_HOM_ALT && side_reg) begin
                    state_next = ST_IDLE;
                    done_next  = 1'b1;
                end else begin
                    state_next = ST_JOB;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                stdz_reg <= req.stdz;
                fa_reg   <= req.freq_a;
                fb_reg   <= req.freq_b;
            end
            ST_PREP: begin
                va_reg   <= {pa_w[30:0], 1'b0};
                vb_reg   <= {pb_w[30:0], 1'b0};
                side_reg <= 1'b0;
                code_reg <= CODE_HOM_REF;
                for (int i = 0; i < 4; i++) begin
                    tbl_a_reg[i] <= raw_entry(2'(i), fa_reg);
                    tbl_b_reg[i] <= raw_entry(2'(i), fb_reg);
                end
            end
            ST_JOB: begin
                zero_reg  <= (v_sel == '0) || (code_reg == CODE_MISSING);
                neg_reg   <= num_w[18];
                div_n_reg <= 64'(mag2_w) << 26;
                rem_reg   <= '0;
                quo_reg   <= '0;
                cnt_reg   <= '0;
            end
            ST_DIV: begin
                rem_reg   <= qbit_w ? (rem_sh_w - {1'b0, v_sel}) : rem_sh_w;
                div_n_reg <= div_n_reg << 1;
                quo_reg   <= {quo_reg[62:0], qbit_w};
                cnt_reg   <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    sq_x_reg   <= {quo_reg[62:0], qbit_w};
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 64'd1 << 62;
                    cnt_reg    <= '0;
                end
            end
            ST_SQRT: begin
                if (sq_x_reg >= trial_w) begin
                    sq_x_reg <= sq_x_reg - trial_w;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 6'd1;
            end
            ST_WRITE: begin
                if (side_reg) tbl_b_reg[code_reg] <= entry_w;
                else          tbl_a_reg[code_reg] <= entry_w;
                if (code_reg == CODE_HOM_ALT) side_reg <= 1'b1;
                code_reg <= code_reg + 2'd1;
            end
            default: ;
        endcase
    end

    assign done  = done_reg;
    assign tbl_a = tbl_a_reg;
    assign tbl_b = tbl_b_reg;

endmodule

// File: src/pgc_lane.sv
// One decode lane: table lookup of a code pair and the three products.
module pgc_lane (
    input  logic                aclk,
    input  logic                load,
    input  logic                use_code,
    input  logic [1:0]          code_a,
    input  logic [1:0]          code_b,
    input  pgc_pkg::dec_tbl_t   tbl_a,
    input  pgc_pkg::dec_tbl_t   tbl_b,
    output pgc_pkg::lane_prod_t prod
);
    import pgc_pkg::*;

    logic signed [ENTRY_W-1:0] xa, xb;
    logic signed [PROD_W-1:0]  sq_a_w, sq_b_w, cross_w;
    lane_prod_t                prod_reg;

    // unused lanes contribute zero
    assign xa      = use_code ? tbl_a[code_a] : '0;
    assign xb      = use_code ? tbl_b[code_b] : '0;
    assign sq_a_w  = xa * xa;
    assign sq_b_w  = xb * xb;
    assign cross_w = xa * xb;

    always_ff @(posedge aclk) begin
        if (load) begin
            prod_reg.sq_a  <= sq_a_w;
            prod_reg.sq_b  <= sq_b_w;
            prod_reg.xprod <= cross_w;
        end
    end

    assign prod = prod_reg;

endmodule

// File: src/pgc_corr.sv
// Correlation in Q1.15: shift-add multiplier, long divider and square root, one step a cycle.
module pgc_corr (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [62:0]        sa,
    input  logic [62:0]        sb,
    input  logic [63:0]        c,
    output pgc_pkg::corr_res_t res
);
    import pgc_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SQRT = 5'b01000,
        ST_FIN  = 5'b10000
    } corr_st_t;

    corr_st_t     state_reg, state_next;
    logic         done_reg;
    logic         valid_reg;
    logic [15:0]  corr_reg;
    logic         neg_reg;
    logic [63:0]  mag_reg;
    logic         pass_reg;
    logic [127:0] mc_reg, acc_reg;
    logic [63:0]  mp_reg;
    logic [125:0] p_reg;
    logic [159:0] cbits_reg;
    logic [125:0] rem_reg;
    logic [32:0]  q_reg;
    logic         ovf_reg;
    logic [7:0]   cnt_reg;
    logic [33:0]  sq_x_reg, sq_r_reg, sq_bit_reg;

    logic         ok_w;
    logic [127:0] acc_next_w;
    logic [126:0] rem_sh_w;
    logic         qbit_w;
    logic [33:0]  trial_w;
    logic [33:0]  qr_w;
    logic [15:0]  qcap_w;
    logic [16:0]  qneg_w;

    assign ok_w       = (sa != '0) && (sb != '0);
    assign acc_next_w = mp_reg[0] ? (acc_reg + mc_reg) : acc_reg;
    assign rem_sh_w   = {rem_reg, cbits_reg[159]};
    assign qbit_w     = rem_sh_w >= {1'b0, p_reg};
    assign trial_w    = sq_r_reg + sq_bit_reg;
    assign qr_w       = (sq_r_reg + 34'd1) >> 1;
    assign qcap_w     = (qr_w > 34'd32767) ? 16'd32767 : qr_w[15:0];
    // negative side reaches -32768
    assign qneg_w     = (qr_w > 34'd32768) ? 17'd32768 : qr_w[16:0];

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (start) state_next = ok_w ? ST_MUL : ST_FIN;
            ST_MUL:  if (cnt_reg == 8'd63 && pass_reg) state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == 8'd159) state_next = ST_SQRT;
            ST_SQRT: if (cnt_reg == 8'd16) state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FIN);
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                valid_reg <= ok_w;
                neg_reg   <= c[63];
                mag_reg   <= c[63] ? (64'd0 - c) : c;
                mc_reg    <= {65'b0, sa};
                mp_reg    <= {1'b0, sb};
                acc_reg   <= '0;
                pass_reg  <= 1'b0;
                cnt_reg   <= '0;
            end
            ST_MUL: begin
                acc_reg <= acc_next_w;
                mc_reg  <= mc_reg << 1;
                mp_reg  <= mp_reg >> 1;
                cnt_reg <= cnt_reg + 8'd1;
                if (cnt_reg == 8'd63) begin
                    cnt_reg <= '0;
                    if (!pass_reg) begin
                        // second pass squares the cross magnitude
                        p_reg    <= acc_next_w[125:0];
                        mc_reg   <= {64'b0, mag_reg};
                        mp_reg   <= mag_reg;
                        acc_reg  <= '0;
                        pass_reg <= 1'b1;
                    end else begin
                        cbits_reg <= {acc_next_w, 32'b0};
                        rem_reg   <= '0;
                        q_reg     <= '0;
                        ovf_reg   <= 1'b0;
                    end
                end
            end
            ST_DIV: begin
                rem_reg   <= qbit_w ? 126'(rem_sh_w - {1'b0, p_reg}) : rem_sh_w[125:0];
                cbits_reg <= cbits_reg << 1;
                q_reg     <= {q_reg[31:0], qbit_w};
                ovf_reg   <= ovf_reg | q_reg[32];
                cnt_reg   <= cnt_reg + 8'd1;
                if (cnt_reg == 8'd159) begin
                    // quotient clamps well above the point where the result saturates
                    sq_x_reg   <= (ovf_reg | q_reg[32]) ? {1'b0, {33{1'b1}}}
                                                        : {1'b0, q_reg[31:0], qbit_w};
                    sq_r_reg   <= '0;
                    sq_bit_reg <= 34'd1 << 32;
                    cnt_reg    <= '0;
                end
            end
            ST_SQRT: begin
                if (sq_x_reg >= trial_w) begin
                    sq_x_reg <= sq_x_reg - trial_w;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                cnt_reg    <= cnt_reg + 8'd1;
            end
            ST_FIN: begin
                if (!valid_reg)   corr_reg <= '0;
                else if (neg_reg) corr_reg <= 16'(17'd0 - qneg_w);
                else              corr_reg <= qcap_w;
            end
            default: ;
        endcase
    end

    assign res.done  = done_reg;
    assign res.valid = valid_reg;
    assign res.corr  = corr_reg;

endmodule
